// ===== src/quadratic_real_roots_macros.svh =====
// assertion macros shared by the quadratic root block
// no dependencies
`ifndef QUADRATIC_REAL_ROOTS_MACROS_SVH
`define QUADRATIC_REAL_ROOTS_MACROS_SVH
// implication checked in the same cycle
`define QRR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("qrr check failed");
// two expressions that must agree at every edge
`define QRR_ASSERT_EQ(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) == (rhs)) \
		else $error("qrr mismatch");
`endif

// ===== src/qrr_pkg.sv =====
// shared constants and types for the quadratic root block
// no dependencies
package qrr_pkg;
	localparam int OUT_WIDTH = 40;
	localparam int OUT_FRAC  = 16;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_NEG_DISC = 2'd1,
		STAT_A_ZERO   = 2'd2
	} qrr_status_t;
endpackage

// ===== src/qrr_sqrt.sv =====
// pipelined integer square root, one result bit per stage
// depends on nothing; used by quadratic_real_roots
module qrr_sqrt #(
	parameter int RW    = 33,
	parameter int TAG_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [2*RW-1:0]   radicand,
	input  logic [TAG_W-1:0]  in_tag,
	output logic              out_valid,
	output logic [RW-1:0]     root,
	output logic [TAG_W-1:0]  out_tag
);
	logic              valid_s [RW+1];
	logic [RW-1:0]     rem_s   [RW+1];
	logic [RW-1:0]     root_s  [RW+1];
	logic [2*RW-1:0]   rad_s   [RW+1];
	logic [TAG_W-1:0]  tag_s   [RW+1];

	assign valid_s[0] = in_valid;
	assign rem_s[0]   = '0;
	assign root_s[0]  = '0;
	assign rad_s[0]   = radicand;
	assign tag_s[0]   = in_tag;

	for (genvar i = 0; i < RW; i++) begin : g_stage
		logic [RW+1:0] cur, trial;
		logic          take;
		assign cur   = {rem_s[i], rad_s[i][2*RW-1 -: 2]};
		assign trial = {root_s[i], 2'b01};
		assign take  = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i+1] <= 1'b0;
			end else begin
				valid_s[i+1] <= valid_s[i];
			end
		end

		// remainder stays below 2^RW until the last step
		always_ff @(posedge clk) begin
			rem_s[i+1]  <= take ? RW'(cur - trial) : RW'(cur);
			root_s[i+1] <= {root_s[i][RW-2:0], take};
			rad_s[i+1]  <= {rad_s[i][2*RW-3:0], 2'b00};
			tag_s[i+1]  <= tag_s[i];
		end
	end

	assign out_valid = valid_s[RW];
	assign root      = root_s[RW];
	assign out_tag   = tag_s[RW];
endmodule

// ===== src/qrr_div.sv =====
// pipelined two-lane unsigned restoring divider with a shared divisor
// depends on nothing; used by quadratic_real_roots
module qrr_div #(
	parameter int NW    = 34,
	parameter int DW    = 17,
	parameter int TAG_W = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [NW-1:0]     num [2],
	input  logic [DW-1:0]     den,
	input  logic [TAG_W-1:0]  in_tag,
	output logic              out_valid,
	output logic [NW-1:0]     quot [2],
	output logic [TAG_W-1:0]  out_tag
);
	logic              valid_s [NW+1];
	logic [NW-1:0]     num_s   [NW+1][2];
	logic [DW-1:0]     rem_s   [NW+1][2];
	logic [DW-1:0]     den_s   [NW+1];
	logic [TAG_W-1:0]  tag_s   [NW+1];

	assign valid_s[0]  = in_valid;
	assign num_s[0][0] = num[0];
	assign num_s[0][1] = num[1];
	assign rem_s[0][0] = '0;
	assign rem_s[0][1] = '0;
	assign den_s[0]    = den;
	assign tag_s[0]    = in_tag;

	for (genvar i = 0; i < NW; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i+1] <= 1'b0;
			end else begin
				valid_s[i+1] <= valid_s[i];
			end
		end

		always_ff @(posedge clk) begin
			den_s[i+1] <= den_s[i];
			tag_s[i+1] <= tag_s[i];
		end

		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic [DW:0] cur;
			logic        take;
			assign cur  = {rem_s[i][l], num_s[i][l][NW-1]};
			assign take = cur >= {1'b0, den_s[i]};
			// quotient bits shift in where dividend bits leave
			always_ff @(posedge clk) begin
				rem_s[i+1][l] <= take ? DW'(cur - {1'b0, den_s[i]}) : DW'(cur);
				num_s[i+1][l] <= {num_s[i][l][NW-2:0], take};
			end
		end
	end

	assign out_valid = valid_s[NW];
	assign quot[0]   = num_s[NW][0];
	assign quot[1]   = num_s[NW][1];
	assign out_tag   = tag_s[NW];
endmodule

// ===== src/quadratic_real_roots.sv =====
// Quadratic real roots. Each beat carries coefficients a, b, c (two's
// complement, common scale). Raise start for one cycle with the coefficients;
// busy is always low, so a new beat may enter every cycle.
// The block forms D = b*b - 4ac, its square root and both roots
// (-b +/- sqrt(D)) / (2a) as signed Q24.16, truncated toward zero and
// saturated to 40 bits. status: 0 real roots, 1 negative discriminant,
// 2 leading coefficient zero; in the last two cases both roots are zero.
// Results leave with done high for one cycle, in input order.
// Pipeline, in order: the product and discriminant registers,
// COEF_WIDTH+17 square root bit stages, the numerator register,
// COEF_WIDTH+18 divider stages and the saturated output register.
// Throughput is one beat per cycle; each square root and
// divider stage produces one bit.
// Reset clears all valid bits; beats in flight are dropped.
// The receiver cannot stall; done is a strobe and must be taken.
// Depends on qrr_pkg, qrr_sqrt, qrr_div and the macro header.
`include "quadratic_real_roots_macros.svh"
module quadratic_real_roots #(
	parameter int COEF_WIDTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [COEF_WIDTH-1:0]          coef_a,
	input  logic signed [COEF_WIDTH-1:0]          coef_b,
	input  logic signed [COEF_WIDTH-1:0]          coef_c,
	output logic                                  done,
	output logic signed [qrr_pkg::OUT_WIDTH-1:0]  root_plus,
	output logic signed [qrr_pkg::OUT_WIDTH-1:0]  root_minus,
	output logic [1:0]                            status
);
	localparam int W     = COEF_WIDTH;
	localparam int QW    = 2*W + 2;
	localparam int SW    = W + 17;
	localparam int DW    = W + 1;
	localparam int NW    = W + 19;
	localparam int NMW   = W + 18;
	localparam int STW   = 2 + 1 + DW + W;
	localparam int OW    = qrr_pkg::OUT_WIDTH;
	localparam int CMPW  = ((NMW > OW) ? NMW : OW) + 1;

	assign busy = 1'b0;

	// stage 1: magnitudes and products
	logic [W-1:0] mag_a, mag_b, mag_c;
	assign mag_a = coef_a[W-1] ? W'(-coef_a) : W'(coef_a);
	assign mag_b = coef_b[W-1] ? W'(-coef_b) : W'(coef_b);
	assign mag_c = coef_c[W-1] ? W'(-coef_c) : W'(coef_c);

	logic                v_s1, addf_s1, azero_s1;
	logic [2*W-1:0]      bsq_s1;
	logic [2*W+1:0]      fac_s1;
	logic signed [W-1:0] a_s1, b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		bsq_s1   <= mag_b * mag_b;
		fac_s1   <= {(2*W)'(mag_a) * (2*W)'(mag_c), 2'b00};
		addf_s1  <= (coef_a[W-1] != coef_c[W-1]) && (coef_c != '0);
		azero_s1 <= coef_a == '0;
		a_s1     <= coef_a;
		b_s1     <= coef_b;
	end

	// stage 2: discriminant and status
	logic [QW-1:0]        disc;
	qrr_pkg::qrr_status_t st1;
	logic [W-1:0]         mag_a1;
	assign disc   = addf_s1 ? QW'(bsq_s1) + QW'(fac_s1) : QW'(bsq_s1) - QW'(fac_s1);
	assign mag_a1 = a_s1[W-1] ? W'(-a_s1) : W'(a_s1);

	always_comb begin
		priority if (azero_s1) begin
			st1 = qrr_pkg::STAT_A_ZERO;
		end else if (!addf_s1 && (QW'(fac_s1) > QW'(bsq_s1))) begin
			st1 = qrr_pkg::STAT_NEG_DISC;
		end else begin
			st1 = qrr_pkg::STAT_OK;
		end
	end

	logic             v_s2;
	logic [QW-1:0]    x_s2;
	logic [STW-1:0]   tag_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		x_s2   <= (st1 == qrr_pkg::STAT_OK) ? disc : '0;
		tag_s2 <= {st1, a_s1[W-1], {mag_a1, 1'b0}, b_s1};
	end

	// square root of D with 16 fraction bits
	logic            sq_valid;
	logic [SW-1:0]   sq_root;
	logic [STW-1:0]  sq_tag;

	qrr_sqrt #(.RW(SW), .TAG_W(STW)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.radicand  ({x_s2, 32'b0}),
		.in_tag    (tag_s2),
		.out_valid (sq_valid),
		.root      (sq_root),
		.out_tag   (sq_tag)
	);

	// stage 3: signed numerators and their magnitudes
	logic [1:0]           st_sq;
	logic                 asign_sq;
	logic [DW-1:0]        den_sq;
	logic signed [W-1:0]  b_sq;
	logic signed [NW-1:0] base, nump, numm;
	assign {st_sq, asign_sq, den_sq, b_sq} = sq_tag;
	assign base = -(NW'(b_sq) <<< qrr_pkg::OUT_FRAC);
	assign nump = base + $signed(NW'(sq_root));
	assign numm = base - $signed(NW'(sq_root));

	logic             v_s3;
	logic [NMW-1:0]   nmag_s3 [2];
	logic [1:0]       neg_s3;
	logic [DW-1:0]    den_s3;
	logic [1:0]       st_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		nmag_s3[0] <= nump[NW-1] ? NMW'(-nump) : NMW'(nump);
		nmag_s3[1] <= numm[NW-1] ? NMW'(-numm) : NMW'(numm);
		neg_s3     <= {numm[NW-1] ^ asign_sq, nump[NW-1] ^ asign_sq};
		den_s3     <= den_sq;
		st_s3      <= st_sq;
	end

	logic            dv_valid;
	logic [NMW-1:0]  dv_quot [2];
	logic [3:0]      dv_tag;

	qrr_div #(.NW(NMW), .DW(DW), .TAG_W(4)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.num       (nmag_s3),
		.den       (den_s3),
		.in_tag    ({st_s3, neg_s3}),
		.out_valid (dv_valid),
		.quot      (dv_quot),
		.out_tag   (dv_tag)
	);

	// output stage: sign, saturation, status
	localparam logic [CMPW-1:0] LIM = CMPW'(1) << (OW - 1);
	logic [OW-1:0] res [2];

	for (genvar l = 0; l < 2; l++) begin : g_sat
		logic [CMPW-1:0] qe, qn, qp;
		assign qe = CMPW'(dv_quot[l]);
		assign qn = (qe > LIM) ? LIM : qe;
		assign qp = (qe > LIM - CMPW'(1)) ? LIM - CMPW'(1) : qe;
		always_comb begin
			if (dv_tag[3:2] != qrr_pkg::STAT_OK) begin
				res[l] = '0;
			end else if (dv_tag[l]) begin
				res[l] = OW'(-qn);
			end else begin
				res[l] = OW'(qp);
			end
		end
	end

	logic          done_q;
	logic [OW-1:0] rp_q, rm_q;
	logic [1:0]    st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		rp_q <= res[0];
		rm_q <= res[1];
		st_q <= dv_tag[3:2];
	end

	assign done       = done_q;
	assign root_plus  = rp_q;
	assign root_minus = rm_q;
	assign status     = st_q;

	`QRR_ASSERT_IMP(a_zero_roots, clk, arst_n, done && (status != qrr_pkg::STAT_OK),
		(root_plus == '0) && (root_minus == '0))
	`QRR_ASSERT_IMP(a_sqrt_latency, clk, arst_n, sq_valid, $past(v_s2, SW))
	`QRR_ASSERT_IMP(a_div_latency, clk, arst_n, dv_valid, $past(v_s3, NMW))
endmodule
